// ----- rtl/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, codes and constants for the loop playback crossfade core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpc_pkg;

   localparam int FRAMES_LOG2_DEF = 16;
   localparam int MAX_FADE_DEF    = 16384;
   localparam int SINE_SIZE_DEF   = 256;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [14:0]        FADE_FRAMES_RST = 15'd384;
   localparam logic signed [35:0] MIX_BIAS        = 36'sd16384;
   localparam longint             Q30             = 64'sd1073741824;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SEEK   = 2'd1,
      OP_RENDER = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      REG_TOTAL_FRAMES = 3'd0,
      REG_LOOP_ENABLE  = 3'd1,
      REG_LOOP_START   = 3'd2,
      REG_LOOP_END     = 3'd3,
      REG_FADE_FRAMES  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      RA_ITEM   = 2'd0,
      RA_CURSOR = 2'd1,
      RA_ORIGIN = 2'd2,
      RA_TARGET = 2'd3
   } ram_sel_type;

   // product selects: interpolation, or sample times gain
   typedef enum logic [2:0] {
      MS_INTERP    = 3'd0,
      MS_LEFT_OUT  = 3'd1,
      MS_LEFT_IN   = 3'd2,
      MS_RIGHT_OUT = 3'd3,
      MS_RIGHT_IN  = 3'd4
   } mac_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REGION,
      ST_FSETUP,
      ST_PLAY_RD,
      ST_PLAY_CAP,
      ST_RD_A,
      ST_RD_B,
      ST_DIV_INIT,
      ST_DIV,
      ST_GIN_MUL,
      ST_GIN_SUM,
      ST_GOUT_MUL,
      ST_GOUT_SUM,
      ST_MIX_L0,
      ST_MIX_L1,
      ST_MIX_R0,
      ST_MIX_R1,
      ST_FADE_END,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [15:0]        address;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic [15:0]        seek_target;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               ended;
      logic [16:0]        cursor_out;
   } rsp_word_type;

   typedef struct packed {
      logic [16:0] total_frames;
      logic        loop_enable;
      logic [16:0] loop_start;
      logic [16:0] loop_end;
      logic [14:0] fade_frames;
   } cfg_type;

   typedef struct packed {
      logic        take_item;
      logic        ram_we;
      ram_sel_type ram_sel;
      logic        seek_begin;
      logic        seek_empty;
      logic        region_calc;
      logic        wrap_begin;
      logic        fade_setup;
      logic        play_step;
      logic        play_cap;
      logic        end_silence;
      logic        cap_a;
      logic        cap_b;
      logic        div_init;
      logic        div_step;
      logic        mac_en;
      logic        mac_acc;
      logic        mac_bias;
      mac_sel_type mac_sel;
      logic        gain_sel;
      logic        gin_ld;
      logic        gout_ld;
      logic        left_ld;
      logic        right_ld;
      logic        fade_adv;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       tf_zero;
      logic       fade_active;
      logic       wrap;
      logic       past_end;
      logic       len_nz;
      logic       div_last;
   } status_type;

   function automatic longint mul_q30(input longint a, input longint b);
      return (a * b) / Q30;
   endfunction

   // quarter sine entry in Q15, odd Taylor series to x^9 in Q30
   function automatic logic [15:0] sine_entry(input int k, input int size_log2);
      longint x;
      longint x2;
      longint p;
      longint y;
      x  = longint'(k) << (30 - size_log2);
      x2 = mul_q30(x, x);
      p  = 64'sd172272;
      p  = -64'sd5026991 + mul_q30(p, x2);
      p  = 64'sd85569306 + mul_q30(p, x2);
      p  = -64'sd693598668 + mul_q30(p, x2);
      p  = 64'sd1686629713 + mul_q30(p, x2);
      y  = mul_q30(p, x);
      if (y < 0) y = 0;
      y = (y + 16384) / 32768;
      if (y > 32768) y = 32768;
      return 16'(y);
   endfunction

endpackage

// ----- rtl/lpc_ram.sv -----
// ----------------------------------------------------------------------------
// lpc_ram
// Single port RAM, write and registered read at one address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/lpc_csr.sv -----
// ----------------------------------------------------------------------------
// lpc_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpc_csr import lpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TOTAL_FRAMES: cfg_in.total_frames = pwdata[16:0];
            REG_LOOP_ENABLE:  cfg_in.loop_enable  = pwdata[0];
            REG_LOOP_START:   cfg_in.loop_start   = pwdata[16:0];
            REG_LOOP_END:     cfg_in.loop_end     = pwdata[16:0];
            REG_FADE_FRAMES:  cfg_in.fade_frames  = pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TOTAL_FRAMES: prdata = CSR_DATA_W'(cfg_ff.total_frames);
         REG_LOOP_ENABLE:  prdata = CSR_DATA_W'(cfg_ff.loop_enable);
         REG_LOOP_START:   prdata = CSR_DATA_W'(cfg_ff.loop_start);
         REG_LOOP_END:     prdata = CSR_DATA_W'(cfg_ff.loop_end);
         REG_FADE_FRAMES:  prdata = CSR_DATA_W'(cfg_ff.fade_frames);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_frames <= '0;
         cfg_ff.loop_enable  <= 1'b0;
         cfg_ff.loop_start   <= '0;
         cfg_ff.loop_end     <= '0;
         cfg_ff.fade_frames  <= FADE_FRAMES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/lpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: steps one word through load, seek or render.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpc_ctrl import lpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = (state_ff == ST_IDLE);
      cmd.take_item = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take_item) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.opcode)
               OP_LOAD: begin
                  cmd.ram_we  = 1'b1;
                  cmd.ram_sel = RA_ITEM;
                  state_in    = ST_IDLE;
               end
               OP_SEEK: begin
                  if (status.tf_zero) begin
                     cmd.seek_empty = 1'b1;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.seek_begin = 1'b1;
                     state_in       = ST_FSETUP;
                  end
               end
               OP_RENDER: begin
                  if (status.tf_zero) begin
                     cmd.end_silence = 1'b1;
                     state_in        = ST_OUT;
                  end else if (status.fade_active) begin
                     state_in = ST_RD_A;
                  end else begin
                     cmd.region_calc = 1'b1;
                     state_in        = ST_REGION;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_REGION: begin
            if (status.wrap) begin
               cmd.wrap_begin = 1'b1;
               state_in       = ST_FSETUP;
            end else if (status.past_end) begin
               cmd.end_silence = 1'b1;
               state_in        = ST_OUT;
            end else begin
               state_in = ST_PLAY_RD;
            end
         end
         ST_FSETUP: begin
            cmd.fade_setup = 1'b1;
            if (status.opcode == OP_SEEK) state_in = ST_IDLE;
            else if (status.len_nz)       state_in = ST_RD_A;
            else                          state_in = ST_PLAY_RD;
         end
         ST_PLAY_RD: begin
            cmd.ram_sel   = RA_CURSOR;
            cmd.play_step = 1'b1;
            state_in      = ST_PLAY_CAP;
         end
         ST_PLAY_CAP: begin
            cmd.play_cap = 1'b1;
            state_in     = ST_OUT;
         end
         ST_RD_A: begin
            cmd.ram_sel = RA_ORIGIN;
            state_in    = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.ram_sel = RA_TARGET;
            cmd.cap_a   = 1'b1;
            state_in    = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.cap_b    = 1'b1;
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_GIN_MUL;
         end
         ST_GIN_MUL: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MS_INTERP;
            state_in    = ST_GIN_SUM;
         end
         ST_GIN_SUM: begin
            cmd.gin_ld = 1'b1;
            state_in   = ST_GOUT_MUL;
         end
         ST_GOUT_MUL: begin
            cmd.gain_sel = 1'b1;
            cmd.mac_en   = 1'b1;
            cmd.mac_sel  = MS_INTERP;
            state_in     = ST_GOUT_SUM;
         end
         ST_GOUT_SUM: begin
            cmd.gain_sel = 1'b1;
            cmd.gout_ld  = 1'b1;
            state_in     = ST_MIX_L0;
         end
         ST_MIX_L0: begin
            cmd.mac_en   = 1'b1;
            cmd.mac_bias = 1'b1;
            cmd.mac_sel  = MS_LEFT_OUT;
            state_in     = ST_MIX_L1;
         end
         ST_MIX_L1: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_acc = 1'b1;
            cmd.mac_sel = MS_LEFT_IN;
            state_in    = ST_MIX_R0;
         end
         ST_MIX_R0: begin
            cmd.left_ld  = 1'b1;
            cmd.mac_en   = 1'b1;
            cmd.mac_bias = 1'b1;
            cmd.mac_sel  = MS_RIGHT_OUT;
            state_in     = ST_MIX_R1;
         end
         ST_MIX_R1: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_acc = 1'b1;
            cmd.mac_sel = MS_RIGHT_IN;
            state_in    = ST_FADE_END;
         end
         ST_FADE_END: begin
            cmd.right_ld = 1'b1;
            cmd.fade_adv = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/lpc_dpath.sv -----
// ----------------------------------------------------------------------------
// lpc_dpath
// Track memory, cursor and fade state, phase divider, gain and mix MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpc_dpath import lpc_pkg::*; #(
   parameter int FRAMES_LOG2     = FRAMES_LOG2_DEF,
   parameter int MAX_FADE        = MAX_FADE_DEF,
   parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   output status_type   status,
   output rsp_word_type rsp_word
);

   localparam int          AW      = FRAMES_LOG2;
   localparam int          LS      = $clog2(SINE_TABLE_SIZE);
   localparam int          QW      = LS + 16;
   localparam int          CW      = $clog2(QW);
   localparam logic [16:0] MAX_LEN = 17'(MAX_FADE);

   // control state
   logic [16:0] cursor_ff, cursor_in;
   logic [15:0] fade_org_ff, fade_org_in;
   logic [15:0] fade_tgt_ff, fade_tgt_in;
   logic [14:0] fade_len_ff, fade_len_in;
   logic [14:0] fade_idx_ff, fade_idx_in;

   // working registers
   req_word_type       item_ff;
   logic [16:0]        rs_ff, re_ff, from_ff, to_ff;
   logic [15:0]        rem_ff;
   logic [QW-1:0]      nlo_ff, quo_ff;
   logic [CW-1:0]      cnt_ff;
   logic signed [35:0] acc_ff;
   logic signed [16:0] gin_ff, gout_ff;
   logic [31:0]        samp_a_ff, samp_b_ff;
   logic signed [15:0] res_l_ff, res_r_ff;
   logic               res_end_ff;
   rsp_word_type       rsp_ff;

   // memory
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wdata, ram_rdata;

   // sine table
   logic [15:0] sine_rom [SINE_TABLE_SIZE+1];

   logic [16:0] tf, tf_m1, rs_c, re_c, tgt_c, len_a, left_from, left_to, len_c, new_cur;
   logic        fs_valid;
   logic [16:0] div_t;
   logic        div_ge;
   logic [15:0] div_rem;
   logic [QW:0]        phs;
   logic [LS:0]        k0, k1;
   logic [15:0]        frac, t0, t1;
   logic signed [16:0] diff;
   logic signed [35:0] interp_q, gain_wide;
   logic signed [17:0] mul_x, mul_y;
   logic signed [35:0] prod, acc_in;
   logic signed [35:0] mix_sh;
   logic signed [15:0] mix_sat;
   logic [14:0]        idx_next;

   for (genvar gi = 0; gi <= SINE_TABLE_SIZE; gi++) begin : g_rom
      assign sine_rom[gi] = sine_entry(gi, LS);
   end

   lpc_ram #(
      .WIDTH (32),
      .DEPTH (1 << AW)
   ) u_track (
      .clock (clock),
      .we    (cmd.ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign ram_wdata = {item_ff.right_in, item_ff.left_in};

   always_comb begin
      case (cmd.ram_sel)
         RA_ITEM:   ram_addr = AW'(item_ff.address);
         RA_CURSOR: ram_addr = AW'(cursor_ff);
         RA_ORIGIN: ram_addr = AW'({1'b0, fade_org_ff} + {2'b0, fade_idx_ff});
         RA_TARGET: ram_addr = AW'({1'b0, fade_tgt_ff} + {2'b0, fade_idx_ff});
         default:   ram_addr = AW'(cursor_ff);
      endcase
   end

   // loop region, seek clamp, fade length
   assign tf    = cfg.total_frames;
   assign tf_m1 = tf - 17'd1;
   assign tgt_c = ({1'b0, item_ff.seek_target} > tf_m1) ? tf_m1 : {1'b0, item_ff.seek_target};

   always_comb begin
      rs_c = '0;
      re_c = tf;
      if (cfg.loop_enable && (cfg.loop_end > cfg.loop_start)) begin
         rs_c = (cfg.loop_start < tf) ? cfg.loop_start : tf;
         re_c = (cfg.loop_end < tf) ? cfg.loop_end : tf;
         if (re_c <= rs_c) begin
            rs_c = '0;
            re_c = tf;
         end
      end
   end

   always_comb begin
      fs_valid  = (tf != 17'd0) && (from_ff < tf) && (to_ff < tf);
      len_a     = (cfg.fade_frames == 15'd0) ? 17'd1 : {2'b0, cfg.fade_frames};
      left_from = tf - from_ff;
      left_to   = tf - to_ff;
      len_c     = len_a;
      if (left_from < len_c) len_c = left_from;
      if (left_to < len_c)   len_c = left_to;
      if (MAX_LEN < len_c)   len_c = MAX_LEN;
      if (!fs_valid)         len_c = '0;
      new_cur = to_ff + len_c;
      if ((item_ff.opcode == OP_SEEK) && (new_cur > tf_m1)) new_cur = tf_m1;
   end

   // restoring divider: phase = ((2i+1) << (LS+15)) / len, one bit a cycle
   assign div_t   = {rem_ff, nlo_ff[QW-1]};
   assign div_ge  = div_t >= {2'b0, fade_len_ff};
   assign div_rem = div_ge ? 16'(div_t - {2'b0, fade_len_ff}) : div_t[15:0];

   // table interpolation
   always_comb begin
      phs  = cmd.gain_sel ? ({1'b1, {QW{1'b0}}} - {1'b0, quo_ff}) : {1'b0, quo_ff};
      k0   = phs[QW:16];
      frac = phs[15:0];
      k1   = k0[LS] ? (LS+1)'(SINE_TABLE_SIZE) : k0 + 1'b1;
      t0   = sine_rom[k0];
      t1   = sine_rom[k1];
      diff = signed'({1'b0, t1}) - signed'({1'b0, t0});
      // divide by 2^16 toward zero
      interp_q  = (acc_ff + (acc_ff[35] ? 36'sd65535 : 36'sd0)) >>> 16;
      gain_wide = interp_q + signed'(36'(t0));
   end

   // shared multiply-accumulate
   always_comb begin
      case (cmd.mac_sel)
         MS_INTERP: begin
            mul_x = {diff[16], diff};
            mul_y = signed'({2'b0, frac});
         end
         MS_LEFT_OUT: begin
            mul_x = signed'({{2{samp_a_ff[15]}}, samp_a_ff[15:0]});
            mul_y = {gout_ff[16], gout_ff};
         end
         MS_LEFT_IN: begin
            mul_x = signed'({{2{samp_b_ff[15]}}, samp_b_ff[15:0]});
            mul_y = {gin_ff[16], gin_ff};
         end
         MS_RIGHT_OUT: begin
            mul_x = signed'({{2{samp_a_ff[31]}}, samp_a_ff[31:16]});
            mul_y = {gout_ff[16], gout_ff};
         end
         MS_RIGHT_IN: begin
            mul_x = signed'({{2{samp_b_ff[31]}}, samp_b_ff[31:16]});
            mul_y = {gin_ff[16], gin_ff};
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      prod = mul_x * mul_y;
      if (cmd.mac_acc)       acc_in = acc_ff + prod;
      else if (cmd.mac_bias) acc_in = MIX_BIAS + prod;
      else                   acc_in = prod;
   end

   // floor shift and saturate
   always_comb begin
      mix_sh = acc_ff >>> 15;
      if (mix_sh > 36'sd32767)       mix_sat = 16'sh7fff;
      else if (mix_sh < -36'sd32768) mix_sat = 16'sh8000;
      else                           mix_sat = mix_sh[15:0];
   end

   // cursor and fade state
   always_comb begin
      cursor_in   = cursor_ff;
      fade_org_in = fade_org_ff;
      fade_tgt_in = fade_tgt_ff;
      fade_len_in = fade_len_ff;
      fade_idx_in = fade_idx_ff;
      idx_next    = fade_idx_ff + 15'd1;
      if (cmd.seek_empty) begin
         cursor_in   = '0;
         fade_len_in = '0;
         fade_idx_in = '0;
      end
      if (cmd.end_silence && !cfg.loop_enable) cursor_in = '0;
      if (cmd.fade_setup) begin
         cursor_in   = new_cur;
         fade_len_in = len_c[14:0];
         fade_idx_in = '0;
         if (fs_valid) begin
            fade_org_in = from_ff[15:0];
            fade_tgt_in = to_ff[15:0];
         end
      end
      if (cmd.play_step) cursor_in = cursor_ff + 17'd1;
      if (cmd.fade_adv) begin
         if (idx_next >= fade_len_ff) begin
            fade_len_in = '0;
            fade_idx_in = '0;
         end else begin
            fade_idx_in = idx_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         fade_org_ff <= '0;
         fade_tgt_ff <= '0;
         fade_len_ff <= '0;
         fade_idx_ff <= '0;
      end else begin
         cursor_ff   <= cursor_in;
         fade_org_ff <= fade_org_in;
         fade_tgt_ff <= fade_tgt_in;
         fade_len_ff <= fade_len_in;
         fade_idx_ff <= fade_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_ff    <= req_word;
         res_end_ff <= 1'b0;
      end
      if (cmd.region_calc) begin
         rs_ff <= rs_c;
         re_ff <= re_c;
      end
      if (cmd.seek_begin) begin
         from_ff <= cursor_ff;
         to_ff   <= tgt_c;
      end
      if (cmd.wrap_begin) begin
         from_ff <= re_ff;
         to_ff   <= rs_ff;
      end
      if (cmd.cap_a) samp_a_ff <= ram_rdata;
      if (cmd.cap_b) samp_b_ff <= ram_rdata;
      if (cmd.div_init) begin
         rem_ff <= {1'b0, fade_idx_ff};
         nlo_ff <= {1'b1, {(QW-1){1'b0}}};
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= div_rem;
         nlo_ff <= {nlo_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], div_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.mac_en)  acc_ff  <= acc_in;
      if (cmd.gin_ld)  gin_ff  <= gain_wide[16:0];
      if (cmd.gout_ld) gout_ff <= gain_wide[16:0];
      if (cmd.play_cap) begin
         res_l_ff <= ram_rdata[15:0];
         res_r_ff <= ram_rdata[31:16];
      end
      if (cmd.end_silence) begin
         res_l_ff   <= '0;
         res_r_ff   <= '0;
         res_end_ff <= 1'b1;
      end
      if (cmd.left_ld)  res_l_ff <= mix_sat;
      if (cmd.right_ld) res_r_ff <= mix_sat;
      if (cmd.out_load) begin
         rsp_ff.left_out   <= res_l_ff;
         rsp_ff.right_out  <= res_r_ff;
         rsp_ff.ended      <= res_end_ff;
         rsp_ff.cursor_out <= cursor_ff;
      end
   end

   assign status.opcode      = item_ff.opcode;
   assign status.tf_zero     = (tf == 17'd0);
   assign status.fade_active = fade_idx_ff < fade_len_ff;
   assign status.wrap        = cfg.loop_enable && (cursor_ff >= re_ff);
   assign status.past_end    = cursor_ff >= tf;
   assign status.len_nz      = len_c != 17'd0;
   assign status.div_last    = cnt_ff == CW'(QW - 1);

   assign rsp_word = rsp_ff;

endmodule

// ----- rtl/loop_playback_crossfade_core.sv -----
// ----------------------------------------------------------------------------
// loop_playback_crossfade_core
// Stereo loop player over a track RAM with equal-power crossfades. A word
// with opcode load writes one frame (left low, right high) and gives no
// result; seek clamps the target, starts a crossfade from the cursor and
// gives no result; render returns one frame and the cursor after it. When
// looping, a cursor at or past the region end wraps to the region start
// with a crossfade, a hard cut when no frames follow the origin. One word
// is in work at a time; the result sits in an output register, so the next
// word is taken while it waits. Load and seek give no result. A crossfade
// render runs the bit-serial phase divider, which retires one quotient bit
// per cycle, and the single shared 18x18 multiplier for two gain
// interpolations and four mix products.
// Track RAM is not cleared at reset; read only frames that were loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loop_playback_crossfade_core import lpc_pkg::*; #(
   parameter int FRAMES_LOG2     = FRAMES_LOG2_DEF,
   parameter int MAX_FADE        = MAX_FADE_DEF,
   parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request words
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // register file: total_frames, loop_enable, loop_start, loop_end, fade_frames
   lpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: decides the path of each word from datapath status
   lpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: track RAM, cursor, fade state, divider, MAC, output register
   lpc_dpath #(
      .FRAMES_LOG2     (FRAMES_LOG2),
      .MAX_FADE        (MAX_FADE),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

   // silence always carries zero samples
   a_ended_silent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.ended |-> (rsp_word.left_out == 16'sd0) &&
                                      (rsp_word.right_out == 16'sd0))
      else $error("ended result with nonzero samples");

   // without looping, running off the end rewinds the cursor
   a_ended_rewind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.ended && !cfg.loop_enable |-> rsp_word.cursor_out == 17'd0)
      else $error("ended result without cursor rewind");

   // one word in work at a time
   a_one_word : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // a new result is only loaded once the previous one has left
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid || rsp_ready)
      else $error("result register overwritten");

endmodule

// ----- tb/loop_playback_crossfade_checker.sv -----
// ----------------------------------------------------------------------------
// loop_playback_crossfade_checker
// Watches the request, result and register ports of the loop player, keeps
// its own model of track RAM, cursor and crossfade, and compares each result
// word field by field with the oldest predicted frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loop_playback_crossfade_checker import lpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_word_type          req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending,
   output int                    frames_checked,
   output int                    fades_seen
);

   localparam int  TBL_SIZE = 256;
   localparam longint Q30V  = 64'sd1073741824;

   logic [31:0]   track [0:65535];
   int unsigned   sine_tbl [0:TBL_SIZE];
   rsp_word_type  frames_due [$];

   // model state and register copies
   int unsigned cursor, fade_from, fade_to, fade_len, fade_pos;
   int unsigned total_frames, loop_start, loop_end, fade_nominal;
   logic        loop_on;

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b) / Q30V;
   endfunction

   function automatic int unsigned quarter_sine(input int k);
      longint x, x2, p, y;
      x  = (longint'(k) <<< 30) / TBL_SIZE;
      x2 = q30_mul(x, x);
      p  = 172272;
      p  = -5026991 + q30_mul(p, x2);
      p  = 85569306 + q30_mul(p, x2);
      p  = -693598668 + q30_mul(p, x2);
      p  = 1686629713 + q30_mul(p, x2);
      y  = q30_mul(p, x);
      if (y < 0) y = 0;
      y = (y + 16384) / 32768;
      if (y > 32768) y = 32768;
      return int'(y);
   endfunction

   function automatic longint gain_of(input longint ph);
      longint k, f, d;
      k = ph >>> 16;
      f = ph & 64'hFFFF;
      if (k >= TBL_SIZE) return sine_tbl[TBL_SIZE];
      d = longint'(sine_tbl[k + 1]) - longint'(sine_tbl[k]);
      return longint'(sine_tbl[k]) + (d * f) / 65536;
   endfunction

   function automatic logic [15:0] blend(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input longint gout, input longint gin);
      longint s;
      s = longint'(a) * gout + longint'(b) * gin + 16384;
      s = s >>> 15;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[15:0];
   endfunction

   function automatic int unsigned begin_fade(input int unsigned from,
                                              input int unsigned to);
      int unsigned len;
      fade_len = 0;
      fade_pos = 0;
      if (total_frames == 0 || from >= total_frames || to >= total_frames) return 0;
      len = (fade_nominal != 0) ? fade_nominal : 1;
      if (total_frames - from < len) len = total_frames - from;
      if (total_frames - to < len) len = total_frames - to;
      if (MAX_FADE_DEF < len) len = MAX_FADE_DEF;
      fade_from = from;
      fade_to   = to;
      fade_len  = len;
      return len;
   endfunction

   task automatic fade_step(output logic [15:0] l, output logic [15:0] r);
      longint ph, gin, gout;
      logic [31:0] a, b;
      ph   = ((longint'(2 * fade_pos + 1) * TBL_SIZE) <<< 15) / fade_len;
      gin  = gain_of(ph);
      gout = gain_of((longint'(TBL_SIZE) <<< 16) - ph);
      a    = track[16'(fade_from + fade_pos)];
      b    = track[16'(fade_to + fade_pos)];
      l    = blend(a[15:0], b[15:0], gout, gin);
      r    = blend(a[31:16], b[31:16], gout, gin);
      fade_pos++;
      fades_seen++;
      if (fade_pos >= fade_len) begin
         fade_len = 0;
         fade_pos = 0;
      end
   endtask

   task automatic play_step(output logic [15:0] l, output logic [15:0] r);
      logic [31:0] s;
      s = track[16'(cursor)];
      l = s[15:0];
      r = s[31:16];
      cursor++;
   endtask

   task automatic render_frame();
      logic [15:0]  l, r;
      logic         ended;
      int unsigned  rs, re, len;
      rsp_word_type f;
      l = '0;
      r = '0;
      ended = 1'b0;
      if (total_frames == 0) begin
         ended = 1'b1;
      end else if (fade_pos < fade_len) begin
         fade_step(l, r);
      end else begin
         rs = 0;
         re = total_frames;
         if (loop_on && loop_end > loop_start) begin
            rs = (loop_start < total_frames) ? loop_start : total_frames;
            re = (loop_end < total_frames) ? loop_end : total_frames;
            if (re <= rs) begin
               rs = 0;
               re = total_frames;
            end
         end
         if (loop_on && cursor >= re) begin
            len = begin_fade(re, rs);
            cursor = rs + len;
            if (len != 0) fade_step(l, r);
            else play_step(l, r);
         end else if (cursor >= total_frames) begin
            ended = 1'b1;
         end else begin
            play_step(l, r);
         end
      end
      if (ended && !loop_on) cursor = 0;
      f.left_out   = l;
      f.right_out  = r;
      f.ended      = ended;
      f.cursor_out = cursor[16:0];
      frames_due.push_back(f);
   endtask

   task automatic take_word(input req_word_type w);
      int unsigned t, len;
      case (w.opcode)
         OP_LOAD: track[w.address] = {w.right_in, w.left_in};
         OP_SEEK: begin
            if (total_frames == 0) begin
               fade_len = 0;
               fade_pos = 0;
               cursor   = 0;
            end else begin
               t = w.seek_target;
               if (t > total_frames - 1) t = total_frames - 1;
               len = begin_fade(cursor, t);
               cursor = t + len;
               if (cursor > total_frames - 1) cursor = total_frames - 1;
            end
         end
         OP_RENDER: render_frame();
         default: ;
      endcase
   endtask

   task automatic compare_frame(input rsp_word_type got);
      rsp_word_type want;
      if (frames_due.size() == 0) begin
         $error("result word with no frame predicted: %h", got);
         fail_count++;
      end else begin
         want = frames_due.pop_front();
         frames_checked++;
         if (got.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
            fail_count++;
         end
         if (got.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
            fail_count++;
         end
         if (got.ended !== want.ended) begin
            $error("ended: expected %0d, got %0d", want.ended, got.ended);
            fail_count++;
         end
         if (got.cursor_out !== want.cursor_out) begin
            $error("cursor_out: expected %0d, got %0d", want.cursor_out, got.cursor_out);
            fail_count++;
         end
      end
   endtask

   initial begin
      fail_count     = 0;
      pending        = 0;
      frames_checked = 0;
      fades_seen     = 0;
      for (int k = 0; k <= TBL_SIZE; k++) sine_tbl[k] = quarter_sine(k);
   end

   always @(posedge clock) begin
      if (reset) begin
         cursor       = 0;
         fade_from    = 0;
         fade_to      = 0;
         fade_len     = 0;
         fade_pos     = 0;
         total_frames = 0;
         loop_on      = 1'b0;
         loop_start   = 0;
         loop_end     = 0;
         fade_nominal = 384;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr >> 2))
               REG_TOTAL_FRAMES: total_frames = pwdata[16:0];
               REG_LOOP_ENABLE:  loop_on      = pwdata[0];
               REG_LOOP_START:   loop_start   = pwdata[16:0];
               REG_LOOP_END:     loop_end     = pwdata[16:0];
               REG_FADE_FRAMES:  fade_nominal = pwdata[14:0];
               default: ;
            endcase
         end
         // results first: a word accepted now cannot produce this result
         if (rsp_valid && rsp_ready) compare_frame(rsp_word);
         if (req_valid && req_ready) take_word(req_word);
      end
      pending = frames_due.size();
   end

endmodule

// ----- tb/loop_playback_crossfade_core_test.sv -----
// ----------------------------------------------------------------------------
// loop_playback_crossfade_core_test
// Drives load, seek and render words into the loop player with bursty
// traffic and a stalling result side, rewriting the registers between
// phases. A checker beside the core predicts every rendered frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loop_playback_crossfade_core_test;
   import lpc_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;   // undefined opcode, ignored
   localparam int LOADED_FRAMES = 264;         // frames 0..263 always written
   localparam int TRACK_CAP     = 260;         // random track sizes stay at or below
   localparam int HIGH_BASE     = 65472;       // top of RAM, for the full track
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE        = 60;          // lets a word still in flight finish

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count, pending, frames_checked, fades_seen;
   int cycles = 0;
   int words_sent = 0;
   int burst_left = 0;
   int mode_left = 0, stall_mode = 0, stall_run = 0;

   loop_playback_crossfade_core uut (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .rsp_valid, .rsp_ready, .rsp_word,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   loop_playback_crossfade_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .rsp_valid, .rsp_ready, .rsp_word,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending, .frames_checked, .fades_seen
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: switches between always ready, coin-flip ready, and
   // mostly ready with long stall runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: begin
               if (stall_run > 0) begin
                  stall_run--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 20);
               end
            end
         endcase
      end
   end

   function automatic req_word_type make_word(input logic [1:0] op,
                                              input logic [15:0] addr,
                                              input logic [15:0] l,
                                              input logic [15:0] r,
                                              input logic [15:0] tgt);
      req_word_type w;
      w.opcode      = op;
      w.address     = addr;
      w.left_in     = l;
      w.right_in    = r;
      w.seek_target = tgt;
      return w;
   endfunction

   // Sender: bursts of random length, random gaps (sometimes none) between.
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic load_frame(input int addr, input logic [15:0] l, input logic [15:0] r);
      send_word(make_word(OP_LOAD, 16'(addr), l, r, $urandom));
   endtask

   task automatic seek_to(input logic [15:0] tgt);
      send_word(make_word(OP_SEEK, $urandom, $urandom, $urandom, tgt));
   endtask

   task automatic render_frames(input int n);
      repeat (n) send_word(make_word(OP_RENDER, $urandom, $urandom, $urandom, $urandom));
   endtask

   // Holds the sender off until every predicted frame is back, then lets the
   // core finish any load or seek still in flight.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; unused upper bits are noise.
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value,
                            input int width);
      logic [31:0] noise;
      noise = $urandom;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= (noise << width) | value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input int total, input logic loop_on, input int lstart,
                           input int lend, input int fade);
      csr_write(REG_TOTAL_FRAMES, total, 17);
      csr_write(REG_LOOP_ENABLE, loop_on, 1);
      csr_write(REG_LOOP_START, lstart, 17);
      csr_write(REG_LOOP_END, lend, 17);
      csr_write(REG_FADE_FRAMES, fade, 15);
   endtask

   function automatic int pick_loop_point();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65536;
         2: return 131071;
         default: return $urandom_range(0, 300);
      endcase
   endfunction

   task automatic random_phase(input int phase, input int items);
      int total, fade, roll;
      case ($urandom_range(0, 4))
         0: total = 1;
         1: total = TRACK_CAP;
         default: total = $urandom_range(2, TRACK_CAP);
      endcase
      case ($urandom_range(0, 6))
         0: fade = 0;              // acts as one frame
         1: fade = 1;
         2: fade = 16384;
         3: fade = 32767;
         4: fade = 384;
         default: fade = $urandom_range(2, 64);
      endcase
      if (phase == 0) fade = 0;
      if (phase == 1) fade = 32767;
      set_regs(total, $urandom_range(0, 3) != 0, pick_loop_point(), pick_loop_point(),
               fade);
      for (int n = 0; n < items; n++) begin
         // one mid-phase hold-off until the core has delivered everything
         if (phase == 3 && n == items / 2) drain();
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            load_frame($urandom_range(0, 3) != 0 ? $urandom_range(0, LOADED_FRAMES - 1)
                                                 : $urandom_range(0, 65535),
                       $urandom, $urandom);
         end else if (roll < 20) begin
            seek_to($urandom_range(0, 1) ? $urandom_range(0, TRACK_CAP) : $urandom);
         end else if (roll < 23) begin
            send_word(make_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
         end else begin
            render_frames(1);
         end
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the low track; first frames hold the sample extremes
      load_frame(0, 16'h7FFF, 16'h8000);
      load_frame(1, 16'h8000, 16'h7FFF);
      load_frame(2, 16'h7FFF, 16'h7FFF);
      load_frame(3, 16'h8000, 16'h8000);
      load_frame(4, 16'h0000, 16'hFFFF);
      for (int a = 5; a < LOADED_FRAMES; a++) load_frame(a, $urandom, $urandom);
      drain();

      // empty track: silence, seeks park the cursor at zero
      render_frames(2);
      seek_to(16'd100);
      render_frames(1);
      drain();
      set_regs(0, 1'b1, 0, 0, 0);
      render_frames(2);
      drain();

      // short loop with an 8-frame fade, wrap, seek, clamp, odd opcode,
      // and a load landing inside an active crossfade
      set_regs(TRACK_CAP, 1'b1, 10, 20, 8);
      render_frames(3);
      seek_to(16'd30);
      load_frame(33, 16'h7FFF, 16'h8000);
      render_frames(9);
      seek_to(16'hFFFF);
      render_frames(2);
      send_word(make_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      seek_to(16'd5);
      render_frames(4);
      drain();

      // full 64K track: top of RAM loaded, play off the end
      for (int a = HIGH_BASE; a < 65536; a++) load_frame(a, $urandom, $urandom);
      drain();
      set_regs(65536, 1'b0, 0, 0, 4);
      seek_to(16'd65500);
      render_frames(37);
      drain();
      // loop that ends exactly at the track end: hard-cut wrap
      set_regs(65536, 1'b1, 65520, 65536, 4);
      seek_to(16'd65530);
      render_frames(10);
      seek_to(16'hFFFF);
      render_frames(3);
      drain();

      for (int p = 0; p < 10; p++) random_phase(p, 70);

      drain();
      $display("Covered %0d words, %0d rendered frames checked, %0d crossfade frames,",
               words_sent, frames_checked, fades_seen);
      $display("across empty, short-loop, full 64K and random register settings.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
